[design/slip_sensor_packet_deframer_core_assert.svh]
// Assertion macros used by the deframer RTL.
`ifndef SLIP_SENSOR_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define SLIP_SENSOR_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SSD_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define SSD_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

[design/ssd_pkg.sv]
// Types, constants and request structs of the SLIP sensor deframer.
`default_nettype none
package ssd_pkg;

	localparam int FRAME_BYTES  = 32;
	localparam int MAX_SENSORS  = 16;
	localparam int STATUS_BYTES = 7;

	localparam int FRM_AW  = $clog2(FRAME_BYTES);
	localparam int CNT_W   = $clog2(FRAME_BYTES + 1);
	localparam int SNS_AW  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int KNOWN_W = $clog2(MAX_SENSORS + 1);
	localparam int DFL_W   = 6;
	localparam int ID_CMP_W = 9;

	localparam logic [7:0] SLIP_END    = 8'hC0;
	localparam logic [7:0] ESC_MARK    = 8'hDB;
	localparam logic [7:0] ESC_SUB_END = 8'hDC;
	localparam logic [7:0] ESC_SUB_ESC = 8'hDD;

	localparam logic [7:0] TYPE_DATA = 8'd1;
	localparam logic [7:0] TYPE_CAL  = 8'd2;
	localparam logic [7:0] TYPE_SYS  = 8'd3;

	localparam int HEADER_LEN = 3;
	localparam int CAL_LEN    = 7;
	localparam int SYS_LEN    = 6;

	localparam logic [DFL_W-1:0] DFL_RESET = 6'd27;

	typedef enum logic [1:0] {
		KIND_PAY = 2'd0,
		KIND_CAL = 2'd1,
		KIND_SYS = 2'd2,
		KIND_QRY = 2'd3
	} kind_t;

	// cal0..cal3 in bytes 0..3, sys0..sys2 in bytes 4..6
	typedef logic [STATUS_BYTES-1:0][7:0] status_t;

	typedef struct packed {
		logic              wr_en;
		logic [FRM_AW-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd_en;
		logic [FRM_AW-1:0] rd_addr;
	} frm_req_t;

	typedef struct packed {
		logic              wr_en;
		logic [SNS_AW-1:0] wr_addr;
		status_t           wr_data;
		logic              rd_en;
		logic [SNS_AW-1:0] rd_addr;
	} tbl_req_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] unit_id;
		logic [4:0] byte_offset;
		logic [7:0] payload_byte;
		status_t    status;
		logic       last;
	} res_t;

endpackage
`default_nettype wire

[design/ssd_if.sv]
// Valid/ready channel interfaces for deframer input items and results.
`default_nettype none
interface ssd_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] rx_byte;
	logic [7:0] query_id;

	modport source (output valid, mode, rx_byte, query_id, input ready);
	modport sink (input valid, mode, rx_byte, query_id, output ready);
endinterface

interface ssd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] unit_id;
	logic [4:0] byte_offset;
	logic [7:0] payload_byte;
	logic [7:0] cal0;
	logic [7:0] cal1;
	logic [7:0] cal2;
	logic [7:0] cal3;
	logic [7:0] sys0;
	logic [7:0] sys1;
	logic [7:0] sys2;
	logic       last;

	modport source (output valid, kind, unit_id, byte_offset, payload_byte,
		cal0, cal1, cal2, cal3, sys0, sys1, sys2, last, input ready);
	modport sink (input valid, kind, unit_id, byte_offset, payload_byte,
		cal0, cal1, cal2, cal3, sys0, sys1, sys2, last, output ready);
endinterface
`default_nettype wire

[design/slip_sensor_packet_deframer_core.sv]
// Top level of the SLIP sensor packet deframer.
//
//  channel   dir  handshake          contents
//  item      in   valid/ready        mode, rx_byte, query_id
//  result    out  valid/ready        kind, unit_id, byte_offset, payload_byte,
//                                    cal0..cal3, sys0..sys2, last
//  cfg       in   cfg_we (no ready)  cfg_wdata = data_frame_length
//
// A non-END byte leaves the block idle and ready for the next item. A data frame END
// streams each payload byte by a frame buffer read, then a result load, through
// the one frame buffer read port. An update END or a query does a status table read,
// then a result load (with the table write-back for an update).
// Reset clears control state and table valid bits at once; no clearing pass.
// A stalled result holds its stage; byte items without results still enter.
`default_nettype none
`include "slip_sensor_packet_deframer_core_assert.svh"
module slip_sensor_packet_deframer_core import ssd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DFL_W-1:0] cfg_wdata,
	ssd_in_if.sink           item,
	ssd_out_if.source        result
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PRD  = 4'b0010,
		S_PWT  = 4'b0100,
		S_TBL  = 4'b1000
	} state_t;

	state_t           state_q;
	logic [DFL_W-1:0] dfl_q;
	logic [CNT_W-1:0] count_q;
	logic             esc_q;
	logic             ovf_q;
	logic [KNOWN_W-1:0] known_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] end_q;
	kind_t            op_q;
	logic             hit_q;
	logic             out_valid_q;

	// header bytes and the last four stored bytes, captured as they are written
	logic [7:0]       type_q;
	logic [7:0]       id_q;
	logic [7:0]       len_q;
	logic [3:0][7:0]  tail_q;
	logic [7:0]       sid_q;
	res_t             res_q;

	frm_req_t         frm_req;
	tbl_req_t         tbl_req;
	logic [7:0]       frm_rd;
	status_t          tbl_rd;
	status_t          merged;

	logic             acc;
	logic             is_byte;
	logic             is_end;
	logic             store;
	logic             room;
	logic [7:0]       dec_byte;
	logic             base_ok;
	logic             id_in_tbl;
	logic             data_ok;
	logic             cal_ok;
	logic             sys_ok;
	logic             out_free;
	logic             res_load;
	logic             pay_last;
	logic [KNOWN_W-1:0] new_known;

	assign acc      = item.valid && item.ready;
	assign is_byte  = acc && !item.mode;
	assign is_end   = is_byte && (item.rx_byte == SLIP_END);
	assign store    = is_byte && !is_end && (esc_q || (item.rx_byte != ESC_MARK));
	assign room     = count_q < CNT_W'(FRAME_BYTES);
	assign out_free = !out_valid_q || result.ready;
	assign res_load = ((state_q == S_PWT) || (state_q == S_TBL)) && out_free;
	assign pay_last = (ptr_q + CNT_W'(1)) == end_q;

	// undo the escape: only the byte right after ESC is translated
	always_comb begin
		dec_byte = item.rx_byte;
		if (esc_q) begin
			if (item.rx_byte == ESC_SUB_END) begin
				dec_byte = SLIP_END;
			end else if (item.rx_byte == ESC_SUB_ESC) begin
				dec_byte = ESC_MARK;
			end
		end
	end

	// frame checks, evaluated on the END byte against the held header
	assign base_ok   = !ovf_q && (count_q >= CNT_W'(HEADER_LEN));
	assign id_in_tbl = ID_CMP_W'(id_q) < ID_CMP_W'(MAX_SENSORS);
	assign data_ok   = base_ok && (type_q == TYPE_DATA)
		&& (8'(count_q) == 8'(dfl_q)) && (len_q == 8'(dfl_q));
	assign cal_ok    = base_ok && (type_q == TYPE_CAL) && id_in_tbl
		&& (count_q == CNT_W'(CAL_LEN)) && (len_q == 8'(CAL_LEN));
	assign sys_ok    = base_ok && (type_q == TYPE_SYS) && id_in_tbl
		&& (count_q == CNT_W'(SYS_LEN)) && (len_q == 8'(SYS_LEN));

	assign new_known = KNOWN_W'(sid_q[SNS_AW-1:0]) + KNOWN_W'(1);

	// merge the frame bytes into the entry read from the table
	always_comb begin
		merged = tbl_rd;
		case (op_q)
			KIND_CAL: begin
				merged[0] = tail_q[3];
				merged[1] = tail_q[2];
				merged[2] = tail_q[1];
				merged[3] = tail_q[0];
			end
			KIND_SYS: begin
				merged[4] = tail_q[2];
				merged[5] = tail_q[1];
				merged[6] = tail_q[0];
			end
			default: begin
			end
		endcase
	end

	// Frame buffer: written only from idle, read only while streaming payload.
	always_comb begin
		frm_req.wr_en   = store && room;
		frm_req.wr_addr = count_q[FRM_AW-1:0];
		frm_req.wr_data = dec_byte;
		frm_req.rd_en   = (state_q == S_PRD);
		frm_req.rd_addr = ptr_q[FRM_AW-1:0];
	end

	// Status table: a read is issued only from idle and its write-back follows
	// in the next state, so a read never overlaps a pending write of the entry.
	always_comb begin
		tbl_req.rd_en   = (is_end && (cal_ok || sys_ok)) || (acc && item.mode);
		tbl_req.rd_addr = item.mode ? item.query_id[SNS_AW-1:0] : id_q[SNS_AW-1:0];
		tbl_req.wr_en   = (state_q == S_TBL) && out_free && (op_q != KIND_QRY);
		tbl_req.wr_addr = sid_q[SNS_AW-1:0];
		tbl_req.wr_data = merged;
	end

	ssd_frame_buf u_frame_buf (
		.clk     (clk),
		.req     (frm_req),
		.rd_data (frm_rd)
	);

	ssd_status_tbl u_status_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.rd_data (tbl_rd)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dfl_q       <= DFL_RESET;
			count_q     <= '0;
			esc_q       <= 1'b0;
			ovf_q       <= 1'b0;
			known_q     <= '0;
			ptr_q       <= '0;
			end_q       <= '0;
			op_q        <= KIND_PAY;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dfl_q <= cfg_wdata;
			end
			// load the result stage, or drain it once the receiver takes it
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (is_end) begin
						// close the frame and start the next one
						count_q <= '0;
						esc_q   <= 1'b0;
						ovf_q   <= 1'b0;
						ptr_q   <= CNT_W'(HEADER_LEN);
						end_q   <= count_q;
						if (data_ok && (count_q > CNT_W'(HEADER_LEN))) begin
							op_q    <= KIND_PAY;
							state_q <= S_PRD;
						end else if (cal_ok) begin
							op_q    <= KIND_CAL;
							state_q <= S_TBL;
						end else if (sys_ok) begin
							op_q    <= KIND_SYS;
							state_q <= S_TBL;
						end
					end else if (is_byte) begin
						if (esc_q) begin
							esc_q <= 1'b0;
						end else if (item.rx_byte == ESC_MARK) begin
							esc_q <= 1'b1;
						end
						if (store) begin
							if (room) begin
								count_q <= count_q + CNT_W'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end else if (acc) begin
						op_q    <= KIND_QRY;
						hit_q   <= ID_CMP_W'(item.query_id) < ID_CMP_W'(known_q);
						state_q <= S_TBL;
					end
				end
				S_PRD: begin
					state_q <= S_PWT;
				end
				S_PWT: begin
					if (out_free) begin
						ptr_q   <= ptr_q + CNT_W'(1);
						state_q <= pay_last ? S_IDLE : S_PRD;
					end
				end
				S_TBL: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if ((op_q != KIND_QRY) && (known_q < new_known)) begin
							known_q <= new_known;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers: header capture, byte history, result stage
	always_ff @(posedge clk) begin
		if (frm_req.wr_en) begin
			if (count_q == CNT_W'(0)) begin
				type_q <= dec_byte;
			end
			if (count_q == CNT_W'(1)) begin
				id_q <= dec_byte;
			end
			if (count_q == CNT_W'(2)) begin
				len_q <= dec_byte;
			end
			tail_q <= {tail_q[2:0], dec_byte};
		end
		if (state_q == S_IDLE) begin
			if (acc && item.mode) begin
				sid_q <= item.query_id;
			end else if (is_end) begin
				sid_q <= id_q;
			end
		end
		if ((state_q == S_PWT) && out_free) begin
			res_q.kind         <= KIND_PAY;
			res_q.unit_id      <= sid_q;
			res_q.byte_offset  <= 5'(ptr_q - CNT_W'(HEADER_LEN));
			res_q.payload_byte <= frm_rd;
			res_q.status       <= '0;
			res_q.last         <= pay_last;
		end else if ((state_q == S_TBL) && out_free) begin
			res_q.kind         <= op_q;
			res_q.unit_id      <= sid_q;
			res_q.byte_offset  <= '0;
			res_q.payload_byte <= '0;
			res_q.status       <= ((op_q == KIND_QRY) && !hit_q) ? '0 : merged;
			res_q.last         <= (op_q != KIND_QRY) || hit_q;
		end
	end

	assign item.ready          = (state_q == S_IDLE);
	assign result.valid        = out_valid_q;
	assign result.kind         = res_q.kind;
	assign result.unit_id      = res_q.unit_id;
	assign result.byte_offset  = res_q.byte_offset;
	assign result.payload_byte = res_q.payload_byte;
	assign result.cal0         = res_q.status[0];
	assign result.cal1         = res_q.status[1];
	assign result.cal2         = res_q.status[2];
	assign result.cal3         = res_q.status[3];
	assign result.sys0         = res_q.status[4];
	assign result.sys1         = res_q.status[5];
	assign result.sys2         = res_q.status[6];
	assign result.last         = res_q.last;

	`SSD_ASSERT(a_count_bound, count_q <= CNT_W'(FRAME_BYTES), "frame count past buffer size")
	`SSD_ASSERT(a_ovf_full, !ovf_q || (count_q == CNT_W'(FRAME_BYTES)), "overflow with room left")
	`SSD_ASSERT(a_known_bound, known_q <= KNOWN_W'(MAX_SENSORS), "known entries past table")
	`SSD_ASSERT(a_pay_ptr, (state_q != S_PWT) || (ptr_q < end_q), "payload pointer past frame")
	`SSD_ASSERT_NEXT(a_end_clears, is_end, (count_q == '0) && !esc_q && !ovf_q, "END left frame state")

endmodule
`default_nettype wire

[design/ssd_frame_buf.sv]
// Frame byte buffer: one write port, one registered read port.
`default_nettype none
module ssd_frame_buf import ssd_pkg::*; (
	input  logic       clk,
	input  frm_req_t   req,
	output logic [7:0] rd_data
);

	logic [7:0] mem [FRAME_BYTES];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

[design/ssd_status_tbl.sv]
// Per-sensor status table: memory with per-entry valid bits, registered read.
`default_nettype none
module ssd_status_tbl import ssd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tbl_req_t req,
	output status_t  rd_data
);

	status_t                mem [MAX_SENSORS];
	logic [MAX_SENSORS-1:0] valid_q;
	status_t                rd_data_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	// an entry never written reads as all zero
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire

[verif/ssd_deframer_checker.sv]
// Result checker for the SLIP sensor deframer: tracks the input channel, predicts, compares.
module ssd_deframer_checker import ssd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DFL_W-1:0] cfg_wdata,
	ssd_in_if                item,
	ssd_out_if               result,
	output int               errors,
	output int               outstanding,
	output int               checked
);

	logic [7:0]       held [FRAME_BYTES];
	int               held_cnt;
	bit               esc_open;
	bit               overflowed;
	status_t          sensor_status [MAX_SENSORS];
	int               known_ids;
	logic [DFL_W-1:0] data_len;
	res_t             expected_q [$];

	function automatic res_t reply(kind_t k, logic [7:0] id, status_t st, logic fin);
		res_t r;
		r = '0;
		r.kind = k;
		r.unit_id = id;
		r.status = st;
		r.last = fin;
		return r;
	endfunction

	task automatic log_failure(input string line);
		$display("[%0t] deframer mismatch: %s", $time, line);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			log_failure($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				checked, name, got, want));
	endtask

	task automatic store_byte(input logic [7:0] b);
		if (held_cnt < FRAME_BYTES) begin
			held[held_cnt] = b;
			held_cnt++;
		end else
			overflowed = 1'b1;
	endtask

	// A closed frame turns into payload items or one table update, or nothing.
	task automatic close_frame();
		logic [7:0] ftype;
		logic [7:0] id;
		logic [7:0] lenb;
		int         count;
		if (overflowed || held_cnt < HEADER_LEN)
			return;
		ftype = held[0];
		id = held[1];
		lenb = held[2];
		if (ftype == TYPE_DATA) begin
			if (held_cnt == int'(data_len) && lenb == 8'(data_len)) begin
				count = held_cnt - HEADER_LEN;
				for (int i = 0; i < count; i++) begin
					res_t r;
					r = reply(KIND_PAY, id, '0, i == count - 1);
					r.byte_offset = 5'(i);
					r.payload_byte = held[HEADER_LEN + i];
					expected_q = {expected_q, r};
				end
			end
		end else if (ftype == TYPE_CAL) begin
			if (held_cnt == CAL_LEN && lenb == CAL_LEN && id < MAX_SENSORS) begin
				for (int i = 0; i < CAL_LEN - HEADER_LEN; i++)
					sensor_status[id][i] = held[HEADER_LEN + i];
				if (known_ids < int'(id) + 1)
					known_ids = int'(id) + 1;
				expected_q = {expected_q, reply(KIND_CAL, id, sensor_status[id], 1'b1)};
			end
		end else if (ftype == TYPE_SYS) begin
			if (held_cnt == SYS_LEN && lenb == SYS_LEN && id < MAX_SENSORS) begin
				for (int i = 0; i < SYS_LEN - HEADER_LEN; i++)
					sensor_status[id][CAL_LEN - HEADER_LEN + i] = held[HEADER_LEN + i];
				if (known_ids < int'(id) + 1)
					known_ids = int'(id) + 1;
				expected_q = {expected_q, reply(KIND_SYS, id, sensor_status[id], 1'b1)};
			end
		end
	endtask

	task automatic predict_item(input logic m, input logic [7:0] rb, input logic [7:0] qid);
		if (m) begin
			if (qid < known_ids && qid < MAX_SENSORS)
				expected_q = {expected_q, reply(KIND_QRY, qid, sensor_status[qid], 1'b1)};
			else
				expected_q = {expected_q, reply(KIND_QRY, qid, '0, 1'b0)};
			return;
		end
		if (rb == SLIP_END) begin
			close_frame();
			held_cnt = 0;
			esc_open = 1'b0;
			overflowed = 1'b0;
		end else if (esc_open) begin
			esc_open = 1'b0;
			if (rb == ESC_SUB_END)
				store_byte(SLIP_END);
			else if (rb == ESC_SUB_ESC)
				store_byte(ESC_MARK);
			else
				store_byte(rb);
		end else if (rb == ESC_MARK)
			esc_open = 1'b1;
		else
			store_byte(rb);
	endtask

	task automatic compare_result();
		res_t want;
		if (expected_q.size() == 0) begin
			log_failure($sformatf("result %0d of kind %0d arrived with nothing expected",
				checked, result.kind));
			checked++;
			return;
		end
		want = expected_q.pop_front();
		check_field("kind", 8'(result.kind), 8'(want.kind));
		check_field("unit_id", result.unit_id, want.unit_id);
		check_field("byte_offset", 8'(result.byte_offset), 8'(want.byte_offset));
		check_field("payload_byte", result.payload_byte, want.payload_byte);
		check_field("cal0", result.cal0, want.status[0]);
		check_field("cal1", result.cal1, want.status[1]);
		check_field("cal2", result.cal2, want.status[2]);
		check_field("cal3", result.cal3, want.status[3]);
		check_field("sys0", result.sys0, want.status[4]);
		check_field("sys1", result.sys1, want.status[5]);
		check_field("sys2", result.sys2, want.status[6]);
		check_field("last", 8'(result.last), 8'(want.last));
		checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt = 0;
			esc_open = 1'b0;
			overflowed = 1'b0;
			known_ids = 0;
			data_len = DFL_RESET;
			for (int i = 0; i < MAX_SENSORS; i++)
				sensor_status[i] = '0;
			expected_q.delete();
			outstanding = 0;
		end else begin
			if (cfg_we)
				data_len = cfg_wdata;
			// predict first so a same-edge result still finds its expectation
			if (item.valid && item.ready)
				predict_item(item.mode, item.rx_byte, item.query_id);
			if (result.valid && result.ready)
				compare_result();
			outstanding = expected_q.size();
		end
	end

endmodule

[verif/tb_slip_sensor_packet_deframer_core.sv]
// Testbench top for the SLIP sensor deframer: clock, reset, stimulus and verdict.
module tb_slip_sensor_packet_deframer_core;
	import ssd_pkg::*;

	localparam int CLK_PERIOD    = 12;
	// longest data frame END: a buffer read and a result load per payload byte, plus pipeline slack
	localparam int SETTLE_CYCLES = 80;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int HOLD_CYCLES   = 400;
	localparam int LIMIT_CYCLES  = 4000000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [DFL_W-1:0] cfg_wdata;

	ssd_in_if  byte_ch ();
	ssd_out_if res_ch ();

	int fail_count;
	int expect_left;
	int results_checked;

	int               items_sent;
	int               queries_sent;
	int               settings_used;
	logic [DFL_W-1:0] frame_len_cfg;   // data frame length the block is set to
	bit               full_rate;       // no gaps on either side while set
	bit               hold_req;        // ask the receiver for one long hold-off

	slip_sensor_packet_deframer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (byte_ch),
		.result    (res_ch)
	);

	ssd_deframer_checker frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.item        (byte_ch),
		.result      (res_ch),
		.errors      (fail_count),
		.outstanding (expect_left),
		.checked     (results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("slip_sensor_packet_deframer_core regression: fail");
		$finish;
	end

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		if (full_rate)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Sensor ids mostly inside the table, some beyond it.
	function automatic logic [7:0] pick_sensor();
		if ($urandom_range(0, 99) < 85)
			return 8'($urandom_range(0, MAX_SENSORS - 1));
		return 8'($urandom_range(MAX_SENSORS, 255));
	endfunction

	function automatic logic [7:0] pick_query();
		if ($urandom_range(0, 99) < 70)
			return 8'($urandom_range(0, MAX_SENSORS + 1));
		return 8'($urandom);
	endfunction

	// Lean payload toward the framing bytes so escapes show up often.
	function automatic logic [7:0] payload_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return SLIP_END;
		if (r < 20)
			return ESC_MARK;
		if (r < 24)
			return ESC_SUB_END;
		return 8'($urandom);
	endfunction

	// Offer one item after a random gap and hold it until the block takes it.
	// Entered and left at a falling edge with valid still high, so a
	// back-to-back item never lowers and raises valid in one step.
	task automatic push_item(input logic m, input logic [7:0] rb, input logic [7:0] qid);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.mode <= m;
		byte_ch.rx_byte <= rb;
		byte_ch.query_id <= qid;
		do
			@(posedge clk);
		while (byte_ch.ready !== 1'b1);
		@(negedge clk);
		items_sent++;
		if (m)
			queries_sent++;
	endtask

	// Unused fields carry random values so every bit moves.
	task automatic send_byte(input logic [7:0] b);
		push_item(1'b0, b, 8'($urandom));
	endtask

	task automatic send_query(input logic [7:0] id);
		push_item(1'b1, 8'($urandom), id);
	endtask

	// Escape the framing bytes the way a SLIP transmitter would.
	task automatic send_coded(input logic [7:0] b);
		if (b == SLIP_END) begin
			send_byte(ESC_MARK);
			send_byte(ESC_SUB_END);
		end else if (b == ESC_MARK) begin
			send_byte(ESC_MARK);
			send_byte(ESC_SUB_ESC);
		end else
			send_byte(b);
	endtask

	task automatic send_frame(input logic [7:0] ftype, input logic [7:0] id,
			input logic [7:0] len_byte, input int body);
		send_coded(ftype);
		send_coded(id);
		send_coded(len_byte);
		repeat (body) send_coded(payload_value());
		send_byte(SLIP_END);
	endtask

	// One random unit: mostly well-formed frames and queries, the rest broken.
	task automatic random_unit();
		int         r;
		int         body;
		logic [7:0] t;
		logic [7:0] lb;
		r = $urandom_range(0, 99);
		if (r < 36)
			send_frame(TYPE_DATA, 8'($urandom), 8'(frame_len_cfg),
				int'(frame_len_cfg) - HEADER_LEN);
		else if (r < 48)
			send_frame(TYPE_CAL, pick_sensor(), 8'(CAL_LEN), CAL_LEN - HEADER_LEN);
		else if (r < 60)
			send_frame(TYPE_SYS, pick_sensor(), 8'(SYS_LEN), SYS_LEN - HEADER_LEN);
		else if (r < 74)
			send_query(pick_query());
		else begin
			case ($urandom_range(0, 6))
				0: begin
					// data frame one byte too long or too short
					body = int'(frame_len_cfg) - HEADER_LEN
						+ (($urandom_range(0, 1) != 0) ? 1 : -1);
					send_frame(TYPE_DATA, 8'($urandom), 8'(frame_len_cfg), body);
				end
				1: begin
					// right size, wrong length byte
					t = ($urandom_range(0, 1) != 0) ? TYPE_CAL : TYPE_SYS;
					lb = 8'($urandom);
					if (lb == CAL_LEN || lb == SYS_LEN)
						lb = ~lb;
					send_frame(t, pick_sensor(), lb,
						(t == TYPE_CAL) ? CAL_LEN - HEADER_LEN : SYS_LEN - HEADER_LEN);
				end
				2: begin
					// unknown frame type
					t = 8'($urandom);
					if (t >= TYPE_DATA && t <= TYPE_SYS)
						t = ~t;
					send_frame(t, 8'($urandom), 8'($urandom_range(0, 40)),
						$urandom_range(0, 6));
				end
				3: begin
					// fewer than three header bytes
					repeat ($urandom_range(0, 2)) send_coded(8'($urandom));
					send_byte(SLIP_END);
				end
				4: begin
					// overrun the frame buffer
					send_frame(TYPE_DATA, 8'($urandom), 8'(frame_len_cfg),
						$urandom_range(FRAME_BYTES - 2, FRAME_BYTES + 1));
				end
				5: begin
					// END arrives while an escape is open
					repeat ($urandom_range(0, 4)) send_coded(8'($urandom));
					send_byte(ESC_MARK);
					send_byte(SLIP_END);
				end
				default: begin
					// raw line noise, then resync on END
					repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
					send_byte(SLIP_END);
				end
			endcase
		end
	endtask

	task automatic run_until(input int item_mark);
		while (items_sent < item_mark)
			random_unit();
	endtask

	// Drop valid, wait for every expected result, then let the block go quiet.
	task automatic settle();
		int spent;
		spent = 0;
		byte_ch.valid <= 1'b0;
		while (expect_left != 0 && spent < DRAIN_LIMIT) begin
			@(negedge clk);
			spent++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the frame length register; call only while the block is idle.
	task automatic write_frame_len(input logic [DFL_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		frame_len_cfg = value;
		settings_used++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Receiver: ready in runs of random length, or one long hold-off on request.
	initial begin : receiver
		int span;
		int r;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				// hold off long enough to back the block up into its input
				res_ch.ready <= 1'b0;
				span = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (full_rate) begin
				res_ch.ready <= 1'b1;
				span = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					res_ch.ready <= 1'b1;
					span = $urandom_range(1, 8);
				end else if (r < 85) begin
					res_ch.ready <= 1'b0;
					span = $urandom_range(1, 3);
				end else if (r < 97) begin
					res_ch.ready <= 1'b0;
					span = $urandom_range(4, 12);
				end else begin
					res_ch.ready <= 1'b0;
					span = $urandom_range(20, 50);
				end
			end
			repeat (span) @(negedge clk);
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = DFL_RESET;
		byte_ch.valid = 1'b0;
		byte_ch.mode = 1'b0;
		byte_ch.rx_byte = '0;
		byte_ch.query_id = '0;
		items_sent = 0;
		queries_sent = 0;
		settings_used = 1;
		frame_len_cfg = DFL_RESET;
		full_rate = 1'b0;
		hold_req = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed opening, frame length still at its reset value.
		// Query an empty table: reply is all zero and not marked known.
		send_query(8'd0);
		// Calibration frame for sensor 5 whose status bytes need every
		// escape form: escaped END, escaped ESC, ESC before a plain byte.
		send_byte(TYPE_CAL);
		send_byte(8'd5);
		send_byte(8'(CAL_LEN));
		send_byte(ESC_MARK);
		send_byte(ESC_SUB_END);
		send_byte(ESC_MARK);
		send_byte(ESC_SUB_ESC);
		send_byte(ESC_MARK);
		send_byte(8'h41);
		send_byte(8'hFF);
		send_byte(SLIP_END);
		// Sensor 3 is below the known count but never written: zeros, known.
		send_query(8'd3);
		send_query(8'd5);
		send_query(8'hFF);
		// System frame for the top table entry.
		send_frame(TYPE_SYS, 8'(MAX_SENSORS - 1), 8'(SYS_LEN), SYS_LEN - HEADER_LEN);
		// Too-short frame, then END while an escape is pending.
		send_byte(TYPE_DATA);
		send_byte(SLIP_END);
		send_byte(TYPE_CAL);
		send_byte(ESC_MARK);
		send_byte(SLIP_END);

		// Random traffic at the reset frame length.
		run_until(130);

		// Seven-byte data frames; back the block up with a long receiver hold-off
		// while frames keep coming at full rate.
		settle();
		write_frame_len(6'd7);
		hold_req = 1'b1;
		full_rate = 1'b1;
		repeat (8)
			send_frame(TYPE_DATA, 8'($urandom), 8'(frame_len_cfg),
				int'(frame_len_cfg) - HEADER_LEN);
		full_rate = 1'b0;
		run_until(210);

		// Longest data frame: first one fills the buffer exactly.
		settle();
		write_frame_len(6'd32);
		send_frame(TYPE_DATA, 8'hFF, 8'(frame_len_cfg), int'(frame_len_cfg) - HEADER_LEN);
		run_until(300);

		// Mid-range length, no idling on either side.
		settle();
		write_frame_len(6'd23);
		full_rate = 1'b1;
		run_until(350);
		full_rate = 1'b0;

		// A random length from 7 up to the buffer size to finish.
		settle();
		write_frame_len(6'($urandom_range(7, FRAME_BYTES)));
		run_until(365);

		settle();
		$display("Covered %0d items (%0d status queries) over %0d frame-length settings,",
			items_sent, queries_sent, settings_used);
		$display("with escapes, rejected and overrun frames; %0d results checked, %0d left.",
			results_checked, expect_left);
		if (fail_count == 0 && expect_left == 0)
			$display("slip_sensor_packet_deframer_core regression: pass");
		else
			$display("slip_sensor_packet_deframer_core regression: fail");
		$finish;
	end

endmodule
